/* sv/multichannel_input_debouncer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel input debouncer.
// Each macro checks one property on the rising edge of clk; reset disables it.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_INPUT_DEBOUNCER_UNIT_DEFINES_SVH
`define MULTICHANNEL_INPUT_DEBOUNCER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MIDU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("debouncer check failed");

// The consequent must hold in the cycle after the antecedent.
`define MIDU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("debouncer check failed");

`endif

/* sv/mid_pkg.sv */
// ----------------------------------------------------------------------------
// mid_pkg
// Shared types, codes and the per-channel debounce step function.
// ----------------------------------------------------------------------------
package mid_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CH_W         = 3;
	localparam int SMP_W        = 2;
	localparam int EN_W         = 8;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = 2;
	localparam int QCNT_W       = 3;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	// Register index as decoded from paddr[2].
	localparam logic REG_CHANNEL_ENABLE = 1'b0;

	localparam logic [SMP_W-1:0] SMP_RELEASED = 2'd0;
	localparam logic [SMP_W-1:0] SMP_PRESSED  = 2'd1;

	typedef enum logic [9:0] {
		DB_RELEASED     = 10'b00_0000_0001,
		DB_RELEASE_EDGE = 10'b00_0000_0010,
		DB_PRESSED      = 10'b00_0000_0100,
		DB_PRESS_EDGE   = 10'b00_0000_1000,
		DB_PRESS_F1     = 10'b00_0001_0000,
		DB_PRESS_F2     = 10'b00_0010_0000,
		DB_PRESS_F3     = 10'b00_0100_0000,
		DB_RELEASE_F1   = 10'b00_1000_0000,
		DB_RELEASE_F2   = 10'b01_0000_0000,
		DB_RELEASE_F3   = 10'b10_0000_0000
	} db_state_t;

	typedef enum logic [1:0] {
		EV_PRESS_EDGE   = 2'd0,
		EV_PRESS_HELD   = 2'd1,
		EV_RELEASE_EDGE = 2'd2,
		EV_RELEASE_HELD = 2'd3
	} ev_res_t;

	// One event word as it travels from the front part to the result port.
	typedef struct packed {
		logic [CH_W-1:0] channel;
		ev_res_t         res;
	} ev_word_t;

	// Queue status seen by its neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		db_state_t nxt;
		logic      ev_valid;
		ev_res_t   res;
	} db_step_t;

	// Next state and event for one valid sample (pressed or released).
	function automatic db_step_t db_step(input db_state_t cur, input logic pressed);
		db_step_t r;
		r.ev_valid = 1'b0;
		r.res      = EV_PRESS_EDGE;
		if (pressed) begin
			unique case (cur)
				DB_PRESS_F1: r.nxt = DB_PRESS_F2;
				DB_PRESS_F2: r.nxt = DB_PRESS_F3;
				DB_PRESS_F3: begin
					r.nxt      = DB_PRESS_EDGE;
					r.ev_valid = 1'b1;
					r.res      = EV_PRESS_EDGE;
				end
				DB_PRESS_EDGE, DB_PRESSED: begin
					r.nxt      = DB_PRESSED;
					r.ev_valid = 1'b1;
					r.res      = EV_PRESS_HELD;
				end
				default: r.nxt = DB_PRESS_F1;
			endcase
		end else begin
			unique case (cur)
				DB_RELEASE_F1: r.nxt = DB_RELEASE_F2;
				DB_RELEASE_F2: r.nxt = DB_RELEASE_F3;
				DB_RELEASE_F3: begin
					r.nxt      = DB_RELEASE_EDGE;
					r.ev_valid = 1'b1;
					r.res      = EV_RELEASE_EDGE;
				end
				DB_RELEASE_EDGE, DB_RELEASED: begin
					r.nxt      = DB_RELEASED;
					r.ev_valid = 1'b1;
					r.res      = EV_RELEASE_HELD;
				end
				default: r.nxt = DB_RELEASE_F1;
			endcase
		end
		return r;
	endfunction

endpackage

/* sv/multichannel_input_debouncer_unit.sv */
// ----------------------------------------------------------------------------
// multichannel_input_debouncer_unit
// Path: an event word is queued, then moved into the result register when it is free.
// Throughput: one sample word per cycle while full is low.
// Reset: asynchronous; all channels disarmed and released, queue emptied.
// ----------------------------------------------------------------------------

// The block debounces up to eight channels. Each pushed word carries one
// scan sample of one channel. A level has to be seen on four scans in a row
// before it is accepted; the fourth sample reports an edge event, and every
// further sample at the same level reports a held event. A sample at the
// opposite level starts filtering over from step one. A no-reading sample,
// or the unused sample code, changes nothing and reports nothing.
//
// The front part keeps the per-channel state in flip-flops, reads the entry
// of the sampled channel, computes the next state and writes it back in the
// same cycle, so consecutive samples of one channel need no forwarding.
// Events go into a four-word queue; the back part moves the oldest one into
// the result register. full follows the queue alone, so a stalled result
// port does not stop sampling until the queue has filled.
//
// The channel_enable register sits at byte address 0. Writing it forces
// every channel whose bit is clear into the released state. A sample for a
// disarmed channel is dropped and also leaves that channel released.
module multichannel_input_debouncer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample side.
	input  logic                          push,
	output logic                          full,
	input  logic [mid_pkg::CH_W-1:0]      channel,
	input  logic [mid_pkg::SMP_W-1:0]     sample,
	// Result side.
	output logic                          empty,
	input  logic                          pop,
	output logic [mid_pkg::CH_W-1:0]      event_channel,
	output logic [1:0]                    event_res,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mid_pkg::APB_AW-1:0]    paddr,
	input  logic [mid_pkg::APB_DW-1:0]    pwdata,
	output logic [mid_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import mid_pkg::*;

	logic [EN_W-1:0] enable_q;
	logic            cfg_we;
	logic            in_take;
	logic            ev_push;
	ev_word_t        ev_word;
	ev_word_t        q_rdata;
	q_status_t       q_status;
	logic            q_rd;

	// The port never waits; a write lands at the end of its access cycle.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CHANNEL_ENABLE);
	assign prdata = (paddr[2] == REG_CHANNEL_ENABLE) ?
		{{(APB_DW - EN_W){1'b0}}, enable_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
		end else if (cfg_we) begin
			enable_q <= pwdata[EN_W-1:0];
		end
	end

	// A sample word is taken whenever the queue has room for its event.
	assign full    = q_status.full;
	assign in_take = push && !q_status.full;

	mid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.channel   (channel),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[EN_W-1:0]),
		.enable    (enable_q),
		.ev_push   (ev_push),
		.ev_word   (ev_word)
	);

	mid_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ev_push),
		.wdata  (ev_word),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.status (q_status)
	);

	mid_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.q_rdata       (q_rdata),
		.q_rd          (q_rd),
		.pop           (pop),
		.empty         (empty),
		.event_channel (event_channel),
		.event_res     (event_res)
	);

endmodule

/* sv/mid_front.sv */
// ----------------------------------------------------------------------------
// mid_front
// Holds the debounce state of every channel, classifies each accepted word
// and pushes the resulting event, if any, into the queue.
// ----------------------------------------------------------------------------
module mid_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_take,
	input  logic [mid_pkg::CH_W-1:0]     channel,
	input  logic [mid_pkg::SMP_W-1:0]    sample,
	input  logic                         cfg_we,
	input  logic [mid_pkg::EN_W-1:0]     cfg_wdata,
	input  logic [mid_pkg::EN_W-1:0]     enable,
	output logic                         ev_push,
	output mid_pkg::ev_word_t            ev_word
);
	import mid_pkg::*;

	db_state_t state_q [NUM_CHANNELS];

	logic      in_range;
	logic      armed;
	logic      smp_valid;
	db_state_t cur;
	db_step_t  stp;

	always_comb begin
		in_range  = int'(channel) < NUM_CHANNELS;
		armed     = in_range && enable[channel];
		smp_valid = (sample == SMP_RELEASED) || (sample == SMP_PRESSED);
		cur       = in_range ? state_q[channel] : DB_RELEASED;
		stp       = db_step(cur, sample == SMP_PRESSED);
	end

	assign ev_push         = in_take && armed && smp_valid && stp.ev_valid;
	assign ev_word.channel = channel;
	assign ev_word.res     = stp.res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				state_q[c] <= DB_RELEASED;
			end
		end else begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (cfg_we && !cfg_wdata[c]) begin
					state_q[c] <= DB_RELEASED;
				end else if (in_take && int'(channel) == c) begin
					if (!armed) begin
						state_q[c] <= DB_RELEASED;
					end else if (smp_valid) begin
						state_q[c] <= stp.nxt;
					end
				end
			end
		end
	end

endmodule

/* sv/mid_queue.sv */
// ----------------------------------------------------------------------------
// mid_queue
// Short first-in first-out queue of event words between front and back.
// ----------------------------------------------------------------------------
module mid_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  mid_pkg::ev_word_t    wdata,
	input  logic                 rd,
	output mid_pkg::ev_word_t    rdata,
	output mid_pkg::q_status_t   status
);
	import mid_pkg::*;

	ev_word_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign rdata        = slot_q[rptr_q];
	assign status.full  = cnt_q == QCNT_W'(QDEPTH);
	assign status.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/mid_back.sv */
// ----------------------------------------------------------------------------
// mid_back
// Result register: takes the oldest queued event word and holds it on the
// result ports until it is popped.
// ----------------------------------------------------------------------------
module mid_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mid_pkg::q_status_t          q_status,
	input  mid_pkg::ev_word_t           q_rdata,
	output logic                        q_rd,
	input  logic                        pop,
	output logic                        empty,
	output logic [mid_pkg::CH_W-1:0]    event_channel,
	output logic [1:0]                  event_res
);
	import mid_pkg::*;

	logic     valid_q;
	ev_word_t word_q;

	assign q_rd          = !q_status.empty && (!valid_q || pop);
	assign empty         = !valid_q;
	assign event_channel = word_q.channel;
	assign event_res     = word_q.res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			word_q <= q_rdata;
		end
	end

endmodule

/* sv/mid_checker.sv */
// ----------------------------------------------------------------------------
// mid_checker
// Port-level checks on the debouncer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "multichannel_input_debouncer_unit_defines.svh"

module mid_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [mid_pkg::CH_W-1:0]      event_channel,
	input  logic [1:0]                    event_res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mid_pkg::APB_AW-1:0]    paddr,
	input  logic [mid_pkg::APB_DW-1:0]    pwdata,
	input  logic [mid_pkg::APB_DW-1:0]    prdata,
	input  logic                          pready
);
	import mid_pkg::*;

	// A waiting result word that is not popped stays, unchanged.
	`MIDU_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(event_channel) && $stable(event_res))

	// Only the enable bits of the register read back as set.
	`MIDU_ASSERT_SAME(a_prdata_upper_zero, 1'b1, prdata[APB_DW-1:EN_W] == '0)

	// A completed write to the enable register reads back on the next cycle.
	`MIDU_ASSERT_NEXT(a_enable_readback, psel && penable && pwrite && pready && (paddr[2] == REG_CHANNEL_ENABLE), (paddr[2] != REG_CHANNEL_ENABLE) || (prdata[EN_W-1:0] == $past(pwdata[EN_W-1:0])))

endmodule

bind multichannel_input_debouncer_unit mid_checker u_mid_checker (.*);

/* verif/multichannel_input_debouncer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_input_debouncer_unit_tb
// Drives scan sample words into the debouncer. A local copy of the
// per-channel debounce state machine predicts every event word, and each
// popped event word is checked against the oldest prediction. The
// channel_enable register is reprogrammed between traffic phases, only after
// every predicted event has been popped.
// ----------------------------------------------------------------------------
module multichannel_input_debouncer_unit_tb;
	import mid_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int CYCLE_LIMIT = 400000;

	// Register map: channel_enable is the only register; the next word
	// address decodes to nothing and must be ignored.
	localparam logic [APB_AW-1:0] ADDR_CHANNEL_ENABLE = 3'd0;
	localparam logic [APB_AW-1:0] ADDR_UNMAPPED       = 3'd4;

	// Sample codes beyond the two levels; both are ignored by the block.
	localparam logic [SMP_W-1:0] SMP_NO_READING = 2'd2;
	localparam logic [SMP_W-1:0] SMP_UNUSED     = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [SMP_W-1:0] smp;
	} scan_word_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		ev_res_t         res;
	} key_event_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  push          = 1'b0;
	logic                  full;
	logic [CH_W-1:0]       channel       = '0;
	logic [SMP_W-1:0]      sample        = '0;
	logic                  empty;
	logic                  pop           = 1'b0;
	logic [CH_W-1:0]       event_channel;
	logic [1:0]            event_res;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [APB_AW-1:0]     paddr         = '0;
	logic [APB_DW-1:0]     pwdata        = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	// Scan words waiting to be pushed, and event words predicted but not
	// yet popped.
	scan_word_t            scan_q[$];
	key_event_t            event_q[$];

	// Shadow of the block's state: per-channel debounce state and the
	// armed mask last written to channel_enable.
	db_state_t             key_state [NUM_CHANNELS];
	logic [EN_W-1:0]       armed_mask    = '0;

	int                    words_queued   = 0;
	int                    words_accepted = 0;
	int                    error_count    = 0;
	int                    cycle_count    = 0;
	int                    send_gap       = 0;
	int                    pop_gap        = 0;
	// While set, neither side inserts idle cycles.
	bit                    calm           = 1'b0;

	multichannel_input_debouncer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.channel       (channel),
		.sample        (sample),
		.empty         (empty),
		.pop           (pop),
		.event_channel (event_channel),
		.event_res     (event_res),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Advances the shadow state of one channel by one accepted scan word and
	// records the event word it reports, if any. A disarmed channel drops the
	// word and falls back to released; a code other than the two levels is
	// dropped without touching the state.
	task automatic debounce_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
		db_state_t  nxt;
		logic       fire;
		key_event_t ev_word;
		fire        = 1'b0;
		ev_word.ch  = ch;
		ev_word.res = EV_PRESS_EDGE;
		nxt         = key_state[ch];
		if (!armed_mask[ch]) begin
			nxt = DB_RELEASED;
		end else if (smp == SMP_PRESSED) begin
			case (key_state[ch])
				DB_PRESS_F1: nxt = DB_PRESS_F2;
				DB_PRESS_F2: nxt = DB_PRESS_F3;
				DB_PRESS_F3: begin
					// Fourth pressed scan in a row: the press is accepted.
					nxt         = DB_PRESS_EDGE;
					fire        = 1'b1;
					ev_word.res = EV_PRESS_EDGE;
				end
				DB_PRESS_EDGE, DB_PRESSED: begin
					nxt         = DB_PRESSED;
					fire        = 1'b1;
					ev_word.res = EV_PRESS_HELD;
				end
				// Any released-side state restarts press filtering.
				default: nxt = DB_PRESS_F1;
			endcase
		end else if (smp == SMP_RELEASED) begin
			case (key_state[ch])
				DB_RELEASE_F1: nxt = DB_RELEASE_F2;
				DB_RELEASE_F2: nxt = DB_RELEASE_F3;
				DB_RELEASE_F3: begin
					nxt         = DB_RELEASE_EDGE;
					fire        = 1'b1;
					ev_word.res = EV_RELEASE_EDGE;
				end
				DB_RELEASE_EDGE, DB_RELEASED: begin
					nxt         = DB_RELEASED;
					fire        = 1'b1;
					ev_word.res = EV_RELEASE_HELD;
				end
				default: nxt = DB_RELEASE_F1;
			endcase
		end
		key_state[ch] = nxt;
		if (fire) begin
			event_q.push_back(ev_word);
		end
	endtask

	// Queues one scan word; returns 1 when the word will reach an armed
	// channel's state machine.
	function automatic int queue_scan(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
		scan_word_t w;
		w.ch  = ch;
		w.smp = smp;
		scan_q.push_back(w);
		words_queued++;
		return (armed_mask[ch] && (smp == SMP_PRESSED || smp == SMP_RELEASED)) ? 1 : 0;
	endfunction

	// The APB tasks are entered right after a rising edge and leave at the next
	// edge after the transfer, so no signal gets two updates in one step.
	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_channel_enable();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_CHANNEL_ENABLE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// prdata still shows the access-cycle value at this edge.
		if (prdata !== {{(APB_DW - EN_W){1'b0}}, armed_mask}) begin
			$error("channel_enable mismatch: expected %0h, actual %0h", armed_mask, prdata);
			error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writing the register releases every channel whose bit is clear.
	task automatic set_channel_enable(input logic [EN_W-1:0] mask);
		apb_write(ADDR_CHANNEL_ENABLE, {{(APB_DW - EN_W){1'b0}}, mask});
		armed_mask = mask;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (!mask[c]) begin
				key_state[c] = DB_RELEASED;
			end
		end
		check_channel_enable();
	endtask

	// Holds the sender back until every queued word has been taken and every
	// predicted event word popped, then lets further clock edges pass before
	// returning.
	task automatic wait_until_idle();
		while (words_accepted != words_queued || event_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	// Random traffic built mostly from runs of one level on one channel, so
	// that the filter steps, edges and held events are all reached. Runs are
	// broken now and then by a no-reading or unused code and by words of
	// other channels; one pick in ten queues a single noise word instead.
	task automatic queue_random_scans(input int target);
		int               useful;
		int               start;
		int               run_len;
		int               k;
		logic [CH_W-1:0]  ch;
		logic [SMP_W-1:0] lvl;
		logic [SMP_W-1:0] smp;
		useful = 0;
		start  = words_queued;
		while (useful < target && words_queued - start < 4 * target + 10) begin
			ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
			if ($urandom_range(0, 3) != 0) begin
				for (k = 0; k < 8 && !armed_mask[ch]; k++) begin
					ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
				end
			end
			if ($urandom_range(0, 9) == 0) begin
				useful += queue_scan(ch, SMP_W'($urandom_range(0, 3)));
			end else begin
				lvl     = $urandom_range(0, 1) ? SMP_PRESSED : SMP_RELEASED;
				run_len = $urandom_range(1, 9);
				for (k = 0; k < run_len; k++) begin
					if ($urandom_range(0, 11) == 0) begin
						smp = $urandom_range(0, 1) ? SMP_NO_READING : SMP_UNUSED;
					end else begin
						smp = lvl;
					end
					useful += queue_scan(ch, smp);
					if ($urandom_range(0, 7) == 0) begin
						useful += queue_scan(CH_W'($urandom_range(0, NUM_CHANNELS - 1)),
							SMP_W'($urandom_range(0, 1)));
					end
				end
			end
		end
	endtask

	// Sender: a word is taken at an edge where push is high and full is low.
	// The prediction is made at that same edge, from the values on the ports.
	always @(posedge clk) begin : scan_driver
		scan_word_t w;
		if (arst_n) begin
			if (push && !full) begin
				debounce_sample(channel, sample);
				words_accepted++;
			end
			if (!push || !full) begin
				if (send_gap > 0) begin
					push <= 1'b0;
					send_gap--;
				end else if (scan_q.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
					push     <= 1'b0;
					send_gap = $urandom_range(0, 10);
				end else if (scan_q.size() != 0) begin
					w = scan_q.pop_front();
					push    <= 1'b1;
					channel <= w.ch;
					sample  <= w.smp;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: an event word is taken at an edge where pop is high and empty
	// is low, and compared field by field with the oldest prediction.
	always @(posedge clk) begin : event_monitor
		key_event_t exp_ev;
		if (arst_n) begin
			if (pop && !empty) begin
				if (event_q.size() == 0) begin
					$error("unexpected event word: event_channel %0d, event_res %0d",
						event_channel, event_res);
					error_count++;
				end else begin
					exp_ev = event_q.pop_front();
					if (event_channel !== exp_ev.ch) begin
						$error("event_channel mismatch: expected %0d, actual %0d",
							exp_ev.ch, event_channel);
						error_count++;
					end
					if (event_res !== exp_ev.res) begin
						$error("event_res mismatch: expected %0d, actual %0d",
							exp_ev.res, event_res);
						error_count++;
					end
				end
			end
			if (pop_gap > 0) begin
				pop <= 1'b0;
				pop_gap--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				pop     <= 1'b0;
				pop_gap = $urandom_range(0, 10);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		int              phase;
		logic [EN_W-1:0] mask;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			key_state[c] = DB_RELEASED;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_channel_enable();

		// Every channel starts disarmed, so these words are dropped.
		void'(queue_scan(3'd3, SMP_PRESSED));
		void'(queue_scan(3'd0, SMP_UNUSED));
		wait_until_idle();

		// Channel 0 walks the whole press path, ignores both unused codes,
		// restarts filtering on each level change and then walks the release
		// path. Channel 7 reaches a press edge.
		set_channel_enable(8'hFF);
		repeat (5) void'(queue_scan(3'd0, SMP_PRESSED));
		void'(queue_scan(3'd0, SMP_NO_READING));
		void'(queue_scan(3'd0, SMP_UNUSED));
		void'(queue_scan(3'd0, SMP_PRESSED));
		void'(queue_scan(3'd0, SMP_RELEASED));
		void'(queue_scan(3'd0, SMP_PRESSED));
		repeat (5) void'(queue_scan(3'd0, SMP_RELEASED));
		repeat (4) void'(queue_scan(3'd7, SMP_PRESSED));
		repeat (2) void'(queue_scan(3'd5, SMP_PRESSED));
		wait_until_idle();

		// Disarming channel 5 mid-filter throws its progress away; a pressed
		// word while disarmed is dropped, and after rearming a released word
		// reports release held straight away.
		set_channel_enable(8'hDF);
		void'(queue_scan(3'd5, SMP_PRESSED));
		wait_until_idle();
		set_channel_enable(8'hFF);
		void'(queue_scan(3'd5, SMP_RELEASED));
		wait_until_idle();

		// A write outside the register map must leave channel_enable alone.
		apb_write(ADDR_UNMAPPED, $urandom);
		check_channel_enable();

		// Random phases under a range of enable masks. The last phase runs
		// with no idling on either side.
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       mask = 8'hFF;
				1:       mask = EN_W'($urandom);
				2:       mask = 8'h00;
				3:       mask = 8'h81;
				4:       mask = 8'h7E;
				5:       mask = EN_W'($urandom);
				6:       mask = 8'h01;
				default: mask = 8'hFF;
			endcase
			set_channel_enable(mask);
			calm = (phase == 7) || ($urandom_range(0, 3) == 0);
			queue_random_scans((mask == '0) ? 10 : 220);
			wait_until_idle();
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
